// File: rtl/core/pbpc_pkg.sv
// ----------------------------------------------------------------------------
// pbpc_pkg
// Shared types and constants of the power button press classifier.
// ----------------------------------------------------------------------------
package pbpc_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TOGGLE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_DELAY_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_FORCE_ON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWERDOWN_HOLD_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ON_HOLD_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT_MS = 3'd6;

  // register reset values
  localparam logic                  RST_PULSE_TOGGLE_MODE  = 1'b1;
  localparam logic                  RST_DIRECT_DELAY_MODE  = 1'b0;
  localparam logic                  RST_ALLOW_FORCE_ON     = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_POWERDOWN_HOLD_MS  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_FORCE_ON_HOLD_MS   = 16'd10000;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS        = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_RELEASE_TIMEOUT_MS = 16'd500;

  typedef struct packed {
    logic                  pulse_toggle_mode;
    logic                  direct_delay_mode;
    logic                  allow_force_on;
    logic [CFG_DATA_W-1:0] powerdown_hold_ms;
    logic [CFG_DATA_W-1:0] force_on_hold_ms;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] release_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic button_level;
  } in_item_t;

  typedef struct packed {
    logic button_pressed;
    logic powerdown_request;
    logic force_on_request;
    logic pressed_at_turnon;
  } out_item_t;

endpackage

// File: rtl/core/pbpc_stream_if.sv
// ----------------------------------------------------------------------------
// pbpc_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pbpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pbpc_cfg.sv
// ----------------------------------------------------------------------------
// pbpc_cfg
// Configuration register file; writes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module pbpc_cfg
  import pbpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_toggle_mode  <= RST_PULSE_TOGGLE_MODE;
      cfg.direct_delay_mode  <= RST_DIRECT_DELAY_MODE;
      cfg.allow_force_on     <= RST_ALLOW_FORCE_ON;
      cfg.powerdown_hold_ms  <= RST_POWERDOWN_HOLD_MS;
      cfg.force_on_hold_ms   <= RST_FORCE_ON_HOLD_MS;
      cfg.debounce_ms        <= RST_DEBOUNCE_MS;
      cfg.release_timeout_ms <= RST_RELEASE_TIMEOUT_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_TOGGLE_MODE:  cfg.pulse_toggle_mode  <= cfg_data[0];
        REG_DIRECT_DELAY_MODE:  cfg.direct_delay_mode  <= cfg_data[0];
        REG_ALLOW_FORCE_ON:     cfg.allow_force_on     <= cfg_data[0];
        REG_POWERDOWN_HOLD_MS:  cfg.powerdown_hold_ms  <= cfg_data;
        REG_FORCE_ON_HOLD_MS:   cfg.force_on_hold_ms   <= cfg_data;
        REG_DEBOUNCE_MS:        cfg.debounce_ms        <= cfg_data;
        REG_RELEASE_TIMEOUT_MS: cfg.release_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/pbpc_core.sv
// ----------------------------------------------------------------------------
// pbpc_core
// Per-tick classifier state and next-state logic; updates on each accepted
// tick and presents the result item for that tick.
// ----------------------------------------------------------------------------
module pbpc_core
  import pbpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  primed;
  logic                  last_level;
  logic                  turnon_press;
  logic [COUNT_BITS-1:0] hold_count;
  logic [COUNT_BITS-1:0] release_count;
  logic                  pressed_flag;
  logic                  powerdown_wish;
  logic                  force_on_wish;
  logic                  force_on_issued;

  logic                  turnon_press_next;
  logic [COUNT_BITS-1:0] hold_count_next;
  logic [COUNT_BITS-1:0] release_count_next;
  logic                  pressed_flag_next;
  logic                  powerdown_wish_next;
  logic                  force_on_wish_next;
  logic                  force_on_issued_next;

  logic                  level, last_eff, tp_eff, rise, fall;
  logic [CMP_W-1:0]      hold_w, rel_w;
  logic [COUNT_BITS-1:0] rel_inc;
  logic                  pd_set, fo_set, deb_set, timeout_hit, fo_pre, fo_out;

  always_comb begin
    level    = item.button_level;
    // first tick primes the edge state
    last_eff = primed ? last_level : level;
    tp_eff   = primed ? turnon_press : level;
    rise     = level & ~last_eff;
    fall     = ~level & last_eff;

    if (rise) begin
      hold_count_next = '0;
    end else if (hold_count == CNT_MAX) begin
      hold_count_next = hold_count;
    end else begin
      hold_count_next = hold_count + 1'b1;
    end
    turnon_press_next = tp_eff & ~fall;
    hold_w = CMP_W'(hold_count_next);

    pd_set  = level & (hold_w >= CMP_W'(cfg.powerdown_hold_ms)) & ~turnon_press_next
              & cfg.pulse_toggle_mode;
    fo_set  = level & (hold_w >= CMP_W'(cfg.force_on_hold_ms)) & turnon_press_next
              & cfg.allow_force_on & cfg.pulse_toggle_mode;
    // a power-down latch zeroes the effective hold, so debounce cannot fire
    deb_set = level & ~pd_set & (hold_w > CMP_W'(cfg.debounce_ms)) & ~turnon_press_next;

    rel_inc     = (release_count == CNT_MAX) ? release_count : release_count + 1'b1;
    rel_w       = CMP_W'(rel_inc);
    timeout_hit = ~level & (rel_w >= CMP_W'(cfg.release_timeout_ms));

    if (level || timeout_hit) begin
      release_count_next = '0;
    end else begin
      release_count_next = rel_inc;
    end

    if (level) begin
      pressed_flag_next = pressed_flag | deb_set;
    end else begin
      pressed_flag_next = pressed_flag & ~timeout_hit;
    end

    powerdown_wish_next  = powerdown_wish | pd_set;
    fo_pre               = force_on_wish | fo_set;
    fo_out               = fo_pre & ~force_on_issued;
    force_on_wish_next   = fo_pre & ~fo_out;
    force_on_issued_next = force_on_issued | fo_out;

    result.button_pressed    = pressed_flag_next;
    result.powerdown_request = cfg.pulse_toggle_mode ? powerdown_wish_next
                               : (cfg.direct_delay_mode & ~pressed_flag_next);
    result.force_on_request  = fo_out;
    result.pressed_at_turnon = turnon_press_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed          <= 1'b0;
      last_level      <= 1'b0;
      turnon_press    <= 1'b0;
      hold_count      <= '0;
      release_count   <= '0;
      pressed_flag    <= 1'b1;
      powerdown_wish  <= 1'b0;
      force_on_wish   <= 1'b0;
      force_on_issued <= 1'b0;
    end else if (step) begin
      primed          <= 1'b1;
      last_level      <= level;
      turnon_press    <= turnon_press_next;
      hold_count      <= hold_count_next;
      release_count   <= release_count_next;
      pressed_flag    <= pressed_flag_next;
      powerdown_wish  <= powerdown_wish_next;
      force_on_wish   <= force_on_wish_next;
      force_on_issued <= force_on_issued_next;
    end
  end

endmodule

// File: rtl/core/pbpc_out_buf.sv
// ----------------------------------------------------------------------------
// pbpc_out_buf
// Output register with a skid stage; takes a new item while one waits.
// ----------------------------------------------------------------------------
module pbpc_out_buf #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     push_data,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output T     out_data
);

  logic skid_valid;
  T     skid_data;
  logic pop;

  assign push_ready = ~skid_valid;
  assign pop        = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/power_button_press_classifier.sv
// ----------------------------------------------------------------------------
// power_button_press_classifier
// Classifies one-millisecond button samples into pressed, power-down and
// force-on indications.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick with the sampled button
// level; each tick yields exactly one result transaction. The classifier
// state updates in the accepting cycle and the result lands in an output
// register backed by a one-entry skid stage, so ticks can stream at one per
// clock and input ready only drops when both output slots are full.
// Configuration writes should be made while no tick is in flight; they take
// effect on the next tick. COUNT_BITS sets the width of the saturating hold
// and release counters.
// ----------------------------------------------------------------------------
module power_button_press_classifier
  import pbpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pbpc_stream_if.sink           in_ch,
  pbpc_stream_if.source         out_ch
);

  cfg_t      cfg;
  out_item_t result;
  logic      buf_ready;
  logic      step;

  // register file
  pbpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a tick is consumed whenever the output side has a free slot
  assign in_ch.ready = buf_ready;
  assign step        = in_ch.valid & buf_ready;

  pbpc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (in_ch.data),
    .result (result)
  );

  // result register plus skid slot
  pbpc_out_buf #(
    .T (out_item_t)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (result),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data)
  );

endmodule

// File: rtl/core/pbpc_checker.sv
// ----------------------------------------------------------------------------
// pbpc_checker
// Port-level assertions for the power button press classifier.
// ----------------------------------------------------------------------------
module pbpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_button_pressed,
  input logic out_powerdown_request,
  input logic out_force_on_request,
  input logic out_pressed_at_turnon
);

  logic fo_seen;
  logic tp_released;

  always_ff @(posedge clk) begin
    if (rst) begin
      fo_seen     <= 1'b0;
      tp_released <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (out_force_on_request) begin
        fo_seen <= 1'b1;
      end
      if (!out_pressed_at_turnon) begin
        tp_released <= 1'b1;
      end
    end
  end

  // force-on pulse is delivered at most once per reset
  a_fo_once: assert property (@(posedge clk) disable iff (rst)
    !(fo_seen && out_valid && out_force_on_request))
    else $error("second force-on request");

  // the turn-on press mark never comes back once released
  a_tp_monotone: assert property (@(posedge clk) disable iff (rst)
    !(tp_released && out_valid && out_pressed_at_turnon))
    else $error("turn-on press mark reappeared");

  // with no result pending the block must take a tick
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // an accepted tick shows up in the next cycle when output was empty
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> out_valid)
    else $error("result missing one cycle after accept");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_button_pressed)
      && $stable(out_powerdown_request) && $stable(out_force_on_request)
      && $stable(out_pressed_at_turnon)))
    else $error("stalled result changed");

endmodule

bind power_button_press_classifier pbpc_checker u_pbpc_checker (
  .clk                   (clk),
  .rst                   (rst),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_button_pressed    (out_ch.data.button_pressed),
  .out_powerdown_request (out_ch.data.powerdown_request),
  .out_force_on_request  (out_ch.data.force_on_request),
  .out_pressed_at_turnon (out_ch.data.pressed_at_turnon)
);

// File: tb/pbpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbpc_tb_checker
// Watches the tick and result channels and the register port of the power
// button press classifier, predicts every result and compares field by field.
// ----------------------------------------------------------------------------
module pbpc_tb_checker
  import pbpc_pkg::*;
#(
  parameter int CNT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  output int                    fail_count,
  output int                    pending
);

  cfg_t             regs;
  out_item_t        class_q[$];
  int               result_num;

  // classifier state
  logic             primed;
  logic             last_lvl;
  logic             on_press;
  logic [CNT_W-1:0] hold_cnt;
  logic [CNT_W-1:0] rel_cnt;
  logic             pressed;
  logic             pd_wish;
  logic             fo_wish;
  logic             fo_issued;

  task automatic note_mismatch(input string msg);
    $display("ERROR result %0d: %s", result_num, msg);
    fail_count++;
  endtask

  function automatic out_item_t classify_tick(input logic lvl);
    logic             rise;
    logic             fall;
    logic [CNT_W-1:0] d;
    out_item_t        r;
    if (!primed) begin
      last_lvl = lvl;
      on_press = lvl;
      primed   = 1'b1;
    end
    rise     = lvl & ~last_lvl;
    fall     = ~lvl & last_lvl;
    last_lvl = lvl;
    if (rise) hold_cnt = '0;
    else if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
    if (fall) on_press = 1'b0;
    if (lvl) begin
      d = hold_cnt;
      if (d >= regs.powerdown_hold_ms && !on_press && regs.pulse_toggle_mode) begin
        pd_wish = 1'b1;
        d = '0;
      end
      if (d >= regs.force_on_hold_ms && on_press && regs.allow_force_on &&
          regs.pulse_toggle_mode) begin
        fo_wish = 1'b1;
        d = '0;
      end
      if (d > regs.debounce_ms && !on_press) pressed = 1'b1;
      rel_cnt = '0;
    end else begin
      if (rel_cnt != '1) rel_cnt = rel_cnt + 1'b1;
      if (rel_cnt >= regs.release_timeout_ms) begin
        pressed = 1'b0;
        rel_cnt = '0;
      end
    end
    r.button_pressed    = pressed;
    r.powerdown_request = regs.pulse_toggle_mode ? pd_wish :
                          (regs.direct_delay_mode ? ~pressed : 1'b0);
    r.force_on_request  = 1'b0;
    if (fo_wish && !fo_issued) begin
      fo_wish            = 1'b0;
      fo_issued          = 1'b1;
      r.force_on_request = 1'b1;
    end
    r.pressed_at_turnon = on_press;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    result_num = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      regs.pulse_toggle_mode  = RST_PULSE_TOGGLE_MODE;
      regs.direct_delay_mode  = RST_DIRECT_DELAY_MODE;
      regs.allow_force_on     = RST_ALLOW_FORCE_ON;
      regs.powerdown_hold_ms  = RST_POWERDOWN_HOLD_MS;
      regs.force_on_hold_ms   = RST_FORCE_ON_HOLD_MS;
      regs.debounce_ms        = RST_DEBOUNCE_MS;
      regs.release_timeout_ms = RST_RELEASE_TIMEOUT_MS;
      primed    = 1'b0;
      last_lvl  = 1'b0;
      on_press  = 1'b0;
      hold_cnt  = '0;
      rel_cnt   = '0;
      pressed   = 1'b1;
      pd_wish   = 1'b0;
      fo_wish   = 1'b0;
      fo_issued = 1'b0;
      class_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PULSE_TOGGLE_MODE:  regs.pulse_toggle_mode  = cfg_data[0];
          REG_DIRECT_DELAY_MODE:  regs.direct_delay_mode  = cfg_data[0];
          REG_ALLOW_FORCE_ON:     regs.allow_force_on     = cfg_data[0];
          REG_POWERDOWN_HOLD_MS:  regs.powerdown_hold_ms  = cfg_data;
          REG_FORCE_ON_HOLD_MS:   regs.force_on_hold_ms   = cfg_data;
          REG_DEBOUNCE_MS:        regs.debounce_ms        = cfg_data;
          REG_RELEASE_TIMEOUT_MS: regs.release_timeout_ms = cfg_data;
          default: ;
        endcase
      end
      // pop before push: a result leaving now belongs to an earlier tick
      if (out_valid && out_ready) begin
        if (class_q.size() == 0) begin
          note_mismatch("result with no tick outstanding");
        end else begin
          want = class_q.pop_front();
          if (out_data.button_pressed !== want.button_pressed)
            note_mismatch($sformatf("button_pressed %b, expected %b",
                                    out_data.button_pressed, want.button_pressed));
          if (out_data.powerdown_request !== want.powerdown_request)
            note_mismatch($sformatf("powerdown_request %b, expected %b",
                                    out_data.powerdown_request, want.powerdown_request));
          if (out_data.force_on_request !== want.force_on_request)
            note_mismatch($sformatf("force_on_request %b, expected %b",
                                    out_data.force_on_request, want.force_on_request));
          if (out_data.pressed_at_turnon !== want.pressed_at_turnon)
            note_mismatch($sformatf("pressed_at_turnon %b, expected %b",
                                    out_data.pressed_at_turnon, want.pressed_at_turnon));
        end
        result_num++;
      end
      if (in_valid && in_ready) class_q.push_back(classify_tick(in_data.button_level));
    end
    pending = class_q.size();
  end

endmodule

// File: tb/tb_power_button_press_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_button_press_classifier
// Stimulus and verdict for the power button press classifier.
// ----------------------------------------------------------------------------
// The checker beside the block predicts every result; this module only makes
// ticks, register settings and backpressure. The run goes through a short
// directed part (turn-on press with force-on, zero timeout and zero debounce,
// an unused register index), one long hold with every threshold at its top,
// then random phases of press/release runs mixed with noise.
// ----------------------------------------------------------------------------
module tb_power_button_press_classifier
  import pbpc_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // beyond the register list
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_TICKS   = 55;
  localparam int HOLDOFF_PHASE = 3;   // phase that starts with a long receiver stall
  localparam int LONG_TICKS    = 40;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  idle_en;       // random idling on both sides
  int                    rx_hold_left;  // long receiver stall, counted down by rx
  int                    cycles;
  int                    fail_count;
  int                    pending;

  pbpc_stream_if #(.T(in_item_t))  tick_if ();
  pbpc_stream_if #(.T(out_item_t)) class_if ();

  power_button_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (tick_if),
    .out_ch    (class_if)
  );

  pbpc_tb_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (tick_if.valid),
    .in_ready   (tick_if.ready),
    .in_data    (tick_if.data),
    .out_valid  (class_if.valid),
    .out_ready  (class_if.ready),
    .out_data   (class_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: also catches results that never arrive
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: a pending long hold-off wins, else random stall bursts
  initial begin
    int burst;
    burst = 0;
    class_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        class_if.ready = 1'b0;
        rx_hold_left--;
      end else if (burst > 0) begin
        class_if.ready = 1'b0;
        burst--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        class_if.ready = 1'b0;
      end else begin
        class_if.ready = 1'b1;
      end
    end
  end

  // one tick transaction; called and returning at a falling edge
  task automatic send_tick(input logic lvl);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      tick_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_if.valid = 1'b1;
    tick_if.data.button_level = lvl;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender pauses until every result is back before touching registers
  task automatic drain;
    tick_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  task automatic load_setting(input cfg_t s);
    drain();
    write_reg(REG_PULSE_TOGGLE_MODE,  {15'd0, s.pulse_toggle_mode});
    write_reg(REG_DIRECT_DELAY_MODE,  {15'd0, s.direct_delay_mode});
    write_reg(REG_ALLOW_FORCE_ON,     {15'd0, s.allow_force_on});
    write_reg(REG_POWERDOWN_HOLD_MS,  s.powerdown_hold_ms);
    write_reg(REG_FORCE_ON_HOLD_MS,   s.force_on_hold_ms);
    write_reg(REG_DEBOUNCE_MS,        s.debounce_ms);
    write_reg(REG_RELEASE_TIMEOUT_MS, s.release_timeout_ms);
    cfg_we = 1'b0;
  endtask

  // thresholds lean to short holds so the press runs reach them, with extremes
  function automatic logic [CFG_DATA_W-1:0] pick_ms();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd1;
      2:       return '1;
      default: return 16'($urandom_range(2, 30));
    endcase
  endfunction

  function automatic cfg_t pick_setting();
    cfg_t s;
    s.pulse_toggle_mode  = 1'($urandom_range(0, 1));
    s.direct_delay_mode  = 1'($urandom_range(0, 1));
    s.allow_force_on     = 1'($urandom_range(0, 1));
    s.powerdown_hold_ms  = pick_ms();
    s.force_on_hold_ms   = pick_ms();
    s.debounce_ms        = pick_ms();
    s.release_timeout_ms = pick_ms();
    return s;
  endfunction

  // mostly clean press/release runs, some chatter
  task automatic send_press_mix(input int n);
    int sent;
    int hi_len;
    int lo_len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        hi_len = $urandom_range(1, 40);
        lo_len = $urandom_range(1, 40);
        repeat (hi_len) send_tick(1'b1);
        repeat (lo_len) send_tick(1'b0);
        sent += hi_len + lo_len;
      end else begin
        lo_len = $urandom_range(1, 8);
        repeat (lo_len) send_tick(1'($urandom_range(0, 1)));
        sent += lo_len;
      end
    end
  endtask

  initial begin
    cfg_t s;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idle_en       = 1'b1;
    rx_hold_left  = 0;
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // turn-on press held: force-on fires once, then release and re-press
    // with zero debounce
    s = '{pulse_toggle_mode: 1'b1, direct_delay_mode: 1'b0, allow_force_on: 1'b1,
          powerdown_hold_ms: 16'hFFFF, force_on_hold_ms: 16'd3, debounce_ms: 16'd0,
          release_timeout_ms: 16'd2};
    load_setting(s);
    repeat (5) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    repeat (2) send_tick(1'b1);

    // direct mode with zero timeout; the unused index must change nothing
    s = '{pulse_toggle_mode: 1'b0, direct_delay_mode: 1'b1, allow_force_on: 1'b0,
          powerdown_hold_ms: 16'hFFFF, force_on_hold_ms: 16'hFFFF, debounce_ms: 16'hFFFF,
          release_timeout_ms: 16'd0};
    load_setting(s);
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_we = 1'b0;
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // long hold with every threshold at its top: nothing latches
    s = '{pulse_toggle_mode: 1'b1, direct_delay_mode: 1'b0, allow_force_on: 1'b1,
          powerdown_hold_ms: 16'hFFFF, force_on_hold_ms: 16'hFFFF, debounce_ms: 16'hFFFF,
          release_timeout_ms: 16'hFFFF};
    load_setting(s);
    idle_en = 1'b0;
    send_tick(1'b0);
    repeat (LONG_TICKS) send_tick(1'b1);
    send_tick(1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setting(pick_setting());
      // some phases run without idling; the last one never idles
      idle_en = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      // receiver stalls long while ticks keep coming, so the block backs up
      if (ph == HOLDOFF_PHASE) rx_hold_left = 80;
      send_press_mix(PHASE_TICKS);
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pbpc_pkg.sv
rtl/core/pbpc_stream_if.sv
rtl/core/pbpc_cfg.sv
rtl/core/pbpc_core.sv
rtl/core/pbpc_out_buf.sv
rtl/core/power_button_press_classifier.sv
rtl/core/pbpc_checker.sv
tb/pbpc_checker.sv
tb/tb_power_button_press_classifier.sv
